>>> hdl/pssa_pkg.sv
// ----------------------------------------------------------------------------
// pssa_pkg
// Shared types and constants of the parity split stacks with average unit:
// item and result payloads, operation and status codes, controller states
// and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pssa_pkg;

  localparam int unsigned DEF_STACK_DEPTH = 32;
  localparam int unsigned DATA_W          = 32;
  localparam int unsigned DEPTH_W         = 6;

  localparam logic [1:0] MODE_PUSH     = 2'd0;
  localparam logic [1:0] MODE_POP_EVEN = 2'd1;
  localparam logic [1:0] MODE_POP_ODD  = 2'd2;

  localparam logic signed [DATA_W-1:0] AVG_EMPTY = -32'sd1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]               mode;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    status_t                  status;
    logic [DEPTH_W-1:0]       even_depth;
    logic [DEPTH_W-1:0]       odd_depth;
    logic signed [DATA_W-1:0] even_average;
    logic signed [DATA_W-1:0] odd_average;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPLY,
    S_DIV_START,
    S_DIV_WAIT,
    S_LOAD
  } ctrl_state_t;

  typedef struct packed {
    logic load_item;
    logic apply;
    logic div_start;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_free;
  } dp_stat_t;

endpackage

>>> hdl/pssa_stream_if.sv
// ----------------------------------------------------------------------------
// pssa_stream_if
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface pssa_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> hdl/pssa_div.sv
// ----------------------------------------------------------------------------
// pssa_div
// Signed-by-unsigned restoring divider, one quotient bit per cycle,
// quotient truncated toward zero and cut to QUOT_W bits.
// ----------------------------------------------------------------------------
module pssa_div #(
  parameter int unsigned DIVIDEND_W = 37,
  parameter int unsigned DIVISOR_W  = 6,
  parameter int unsigned QUOT_W     = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [DIVIDEND_W-1:0] dividend,
  input  logic        [DIVISOR_W-1:0]  divisor,
  output logic                         busy,
  output logic signed [QUOT_W-1:0]     quotient
);

  localparam int unsigned STEP_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dvsr;
  logic                  neg;
  logic [STEP_W-1:0]     steps;

  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;
  logic [QUOT_W-1:0]     mag;

  assign trial = {rem, quo[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, dvsr};
  assign fits  = trial >= {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= STEP_W'(DIVIDEND_W);
    end else if (busy) begin
      steps <= steps - 1'b1;
      if (steps == STEP_W'(1)) busy <= 1'b0;
    end
  end

  // work on the magnitude, restore the sign at the end
  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= dividend[DIVIDEND_W-1];
      quo  <= dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-dividend) : DIVIDEND_W'(dividend);
      rem  <= '0;
      dvsr <= divisor;
    end else if (busy) begin
      quo <= {quo[DIVIDEND_W-2:0], fits};
      rem <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end
  end

  assign mag      = quo[QUOT_W-1:0];
  assign quotient = neg ? -mag : mag;

endmodule

>>> hdl/pssa_datapath.sv
// ----------------------------------------------------------------------------
// pssa_datapath
// Both stacks with their counts and running sums, the two average dividers
// and the result register.
// ----------------------------------------------------------------------------
module pssa_datapath #(
  parameter int unsigned STACK_DEPTH = pssa_pkg::DEF_STACK_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  pssa_pkg::ctrl_cmd_t ctl,
  output pssa_pkg::dp_stat_t  stat,
  input  pssa_pkg::cmd_t      cmd_payload,
  output logic                res_valid,
  input  logic                res_ready,
  output pssa_pkg::res_t      res_payload
);
  import pssa_pkg::*;

  localparam int unsigned CNT_W   = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ADDR_W  = $clog2(STACK_DEPTH);
  localparam int unsigned TOTAL_W = DATA_W + ADDR_W;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);

  logic [1:0]                mode;
  logic signed [DATA_W-1:0]  value;
  status_t                   status;
  status_t                   status_next;

  logic [CNT_W-1:0]          even_cnt;
  logic [CNT_W-1:0]          odd_cnt;
  logic signed [TOTAL_W-1:0] even_total;
  logic signed [TOTAL_W-1:0] odd_total;

  logic [DATA_W-1:0]         even_mem [STACK_DEPTH];
  logic [DATA_W-1:0]         odd_mem  [STACK_DEPTH];
  logic signed [DATA_W-1:0]  even_rd;
  logic signed [DATA_W-1:0]  odd_rd;
  logic [ADDR_W-1:0]         even_top;
  logic [ADDR_W-1:0]         odd_top;

  logic push_even, push_odd, drop_even, drop_odd;
  logic signed [TOTAL_W-1:0] value_ext, even_rd_ext, odd_rd_ext;

  logic                      even_busy, odd_busy;
  logic signed [DATA_W-1:0]  even_quot, odd_quot;

  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      mode  <= cmd_payload.mode;
      value <= cmd_payload.value;
    end
  end

  always_comb begin
    push_even   = 1'b0;
    push_odd    = 1'b0;
    drop_even   = 1'b0;
    drop_odd    = 1'b0;
    status_next = ST_DONE;
    unique case (mode)
      MODE_PUSH: begin
        if (value[0]) begin
          if (odd_cnt == FULL_CNT) status_next = ST_FULL;
          else push_odd = 1'b1;
        end else begin
          if (even_cnt == FULL_CNT) status_next = ST_FULL;
          else push_even = 1'b1;
        end
      end
      MODE_POP_EVEN: begin
        if (even_cnt == '0) status_next = ST_EMPTY;
        else drop_even = 1'b1;
      end
      MODE_POP_ODD: begin
        if (odd_cnt == '0) status_next = ST_EMPTY;
        else drop_odd = 1'b1;
      end
      default: ;
    endcase
  end

  assign value_ext   = TOTAL_W'(value);
  assign even_rd_ext = TOTAL_W'(even_rd);
  assign odd_rd_ext  = TOTAL_W'(odd_rd);
  assign even_top    = ADDR_W'(even_cnt - 1'b1);
  assign odd_top     = ADDR_W'(odd_cnt - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      even_cnt   <= '0;
      odd_cnt    <= '0;
      even_total <= '0;
      odd_total  <= '0;
    end else if (ctl.apply) begin
      if (push_even) begin
        even_cnt   <= even_cnt + 1'b1;
        even_total <= even_total + value_ext;
      end
      if (drop_even) begin
        even_cnt   <= even_cnt - 1'b1;
        even_total <= even_total - even_rd_ext;
      end
      if (push_odd) begin
        odd_cnt   <= odd_cnt + 1'b1;
        odd_total <= odd_total + value_ext;
      end
      if (drop_odd) begin
        odd_cnt   <= odd_cnt - 1'b1;
        odd_total <= odd_total - odd_rd_ext;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.apply) status <= status_next;
  end

  // top entry is read every cycle; counts are steady from accept to apply
  always_ff @(posedge clk) begin
    if (ctl.apply && push_even) even_mem[even_cnt[ADDR_W-1:0]] <= value;
    even_rd <= even_mem[even_top];
  end

  always_ff @(posedge clk) begin
    if (ctl.apply && push_odd) odd_mem[odd_cnt[ADDR_W-1:0]] <= value;
    odd_rd <= odd_mem[odd_top];
  end

  pssa_div #(
    .DIVIDEND_W (TOTAL_W),
    .DIVISOR_W  (CNT_W),
    .QUOT_W     (DATA_W)
  ) u_div_even (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .dividend (even_total),
    .divisor  (even_cnt),
    .busy     (even_busy),
    .quotient (even_quot)
  );

  pssa_div #(
    .DIVIDEND_W (TOTAL_W),
    .DIVISOR_W  (CNT_W),
    .QUOT_W     (DATA_W)
  ) u_div_odd (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .dividend (odd_total),
    .divisor  (odd_cnt),
    .busy     (odd_busy),
    .quotient (odd_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctl.load_out) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      res_payload.status       <= status;
      res_payload.even_depth   <= DEPTH_W'(even_cnt);
      res_payload.odd_depth    <= DEPTH_W'(odd_cnt);
      res_payload.even_average <= (even_cnt == '0) ? AVG_EMPTY : even_quot;
      res_payload.odd_average  <= (odd_cnt == '0) ? AVG_EMPTY : odd_quot;
    end
  end

  assign stat.div_busy = even_busy | odd_busy;
  assign stat.out_free = !res_valid || res_ready;

endmodule

>>> hdl/pssa_ctrl.sv
// ----------------------------------------------------------------------------
// pssa_ctrl
// Sequencer: take an item, apply it to the stacks, run both dividers,
// then hand the beat to the result register once it is free.
// ----------------------------------------------------------------------------
module pssa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  pssa_pkg::dp_stat_t  stat,
  output pssa_pkg::ctrl_cmd_t ctl
);
  import pssa_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (cmd_valid) state_next = S_APPLY;
      S_APPLY:     state_next = S_DIV_START;
      S_DIV_START: state_next = S_DIV_WAIT;
      S_DIV_WAIT:  if (!stat.div_busy) state_next = S_LOAD;
      S_LOAD:      if (stat.out_free) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready     = 1'b0;
    ctl           = '0;
    unique case (state)
      S_IDLE: begin
        cmd_ready     = 1'b1;
        ctl.load_item = cmd_valid;
      end
      S_APPLY:     ctl.apply     = 1'b1;
      S_DIV_START: ctl.div_start = 1'b1;
      S_DIV_WAIT:  ;
      S_LOAD:      ctl.load_out  = stat.out_free;
      default:     ;
    endcase
  end

endmodule

>>> hdl/parity_split_stacks_with_average_unit.sv
// ----------------------------------------------------------------------------
// parity_split_stacks_with_average_unit
// Two bounded stacks split by value parity, reporting depths and averages.
// ----------------------------------------------------------------------------
// The two averages come from a pair of bit-serial dividers working side by
// side, one quotient bit per cycle, on the running sums, which are TOTAL_W =
// 32 + log2(STACK_DEPTH) bits wide. One item is in work at a time; the next
// is taken while the previous result still waits in the output register.
module parity_split_stacks_with_average_unit #(
  parameter int unsigned STACK_DEPTH = pssa_pkg::DEF_STACK_DEPTH
) (
  input logic          clk,
  input logic          rst,
  pssa_stream_if.sink   cmd,
  pssa_stream_if.source res
);
  import pssa_pkg::*;

  ctrl_cmd_t ctl;
  dp_stat_t  stat;
  logic      ready;
  logic      valid;
  res_t      payload;

  pssa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_ready (ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  pssa_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .stat        (stat),
    .cmd_payload (cmd.payload),
    .res_valid   (valid),
    .res_ready   (res.ready),
    .res_payload (payload)
  );

  assign cmd.ready   = ready;
  assign res.valid   = valid;
  assign res.payload = payload;

endmodule

>>> hdl/pssa_checker.sv
// ----------------------------------------------------------------------------
// pssa_checker
// Port-level checks: result stall behaviour, beats in flight, and the
// empty-stack average.
// ----------------------------------------------------------------------------
module pssa_checker #(
  parameter int unsigned STACK_DEPTH = pssa_pkg::DEF_STACK_DEPTH
) (
  input logic           clk,
  input logic           rst,
  input logic           cmd_valid,
  input logic           cmd_ready,
  input logic           res_valid,
  input logic           res_ready,
  input pssa_pkg::res_t res_payload
);
  import pssa_pkg::*;

  logic [1:0] inflight;
  logic       acc_in;
  logic       acc_out;

  assign acc_in  = cmd_valid && cmd_ready;
  assign acc_out = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) inflight <= '0;
    else     inflight <= inflight + {1'b0, acc_in} - {1'b0, acc_out};
  end

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_payload))
    else $error("result beat dropped or changed while stalled");

  // one item in work plus one waiting in the output register at most
  a_inflight_max: assert property (@(posedge clk) disable iff (rst)
    inflight != 2'd3)
    else $error("more than two items in flight");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> inflight != 2'd0)
    else $error("result beat without an accepted item");

  // depth field is exact only below 64 entries
  a_empty_avg: assert property (@(posedge clk) disable iff (rst)
    res_valid && (STACK_DEPTH < 64) |->
      (res_payload.even_depth != '0 || res_payload.even_average == AVG_EMPTY) &&
      (res_payload.odd_depth != '0 || res_payload.odd_average == AVG_EMPTY))
    else $error("empty stack average is not minus one");

endmodule

bind parity_split_stacks_with_average_unit pssa_checker #(
  .STACK_DEPTH (STACK_DEPTH)
) u_pssa_checker (
  .clk         (clk),
  .rst         (rst),
  .cmd_valid   (cmd.valid),
  .cmd_ready   (cmd.ready),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .res_payload (res.payload)
);
